// File: rtl/core/sbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbpe_pkg;

  localparam logic [2:0] ACT_MOVE   = 3'd0;
  localparam logic [2:0] ACT_STOP   = 3'd1;
  localparam logic [2:0] ACT_SET_ID = 3'd2;
  localparam logic [2:0] ACT_LIMIT  = 3'd3;
  localparam logic [2:0] ACT_LOAD   = 3'd4;
  localparam logic [2:0] ACT_UNLOAD = 3'd5;
  localparam logic [2:0] ACT_READ   = 3'd6;
  localparam logic [2:0] ACT_RX     = 3'd7;

  localparam logic [7:0] HDR       = 8'h55;
  localparam logic [7:0] CMD_MOVE  = 8'h01;
  localparam logic [7:0] CMD_STOP  = 8'h0C;
  localparam logic [7:0] CMD_ID    = 8'h0D;
  localparam logic [7:0] CMD_LIMIT = 8'h14;
  localparam logic [7:0] CMD_POS   = 8'h1C;
  localparam logic [7:0] CMD_LOAD  = 8'h1F;

  localparam logic [15:0] ANGLE_MAX = 16'd1000;
  localparam logic [15:0] TIME_MAX  = 16'd30000;
  localparam logic [7:0]  ID_MAX    = 8'd253;
  localparam logic [7:0]  ID_RESET  = 8'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HEADER  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  localparam logic [2:0] REPLY_STORED = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] angle;
    logic [15:0] second_angle;
    logic [15:0] time_ms;
    logic [7:0]  new_id;
    logic [7:0]  rx_byte;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic [1:0]  read_status;
    logic [15:0] read_angle;
  } res_t;

  // One frame or one read result, handed from front to back.
  typedef struct packed {
    logic            is_read;
    logic [7:0]      cmd;
    logic [7:0]      id;
    logic [2:0]      nprm;
    logic [3:0][7:0] prm;
    logic [7:0]      chk;
    logic [1:0]      status;
    logic [15:0]     angle;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/core/sbpe_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module sbpe_job_fifo import sbpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sbpe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sbpe_front import sbpe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire cmd_t       item,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_id,
  output logic            job_push,
  output job_t            job
);

  logic [7:0] current_id;
  logic       awaiting;
  logic [2:0] reply_count;
  logic [7:0] reply_bytes [7];

  logic       job_ok;
  logic [15:0] a_cl;
  logic [15:0] t_cl;
  logic [7:0] frame_sum;
  logic [7:0] reply_sum;
  logic [2:0] len;

  always_comb begin
    a_cl = (item.angle > ANGLE_MAX) ? ANGLE_MAX : item.angle;
    t_cl = (item.time_ms > TIME_MAX) ? TIME_MAX : item.time_ms;
    reply_sum = reply_bytes[2] + reply_bytes[3] + reply_bytes[4] + reply_bytes[5]
              + reply_bytes[6];

    job        = '0;
    job.id     = current_id;
    job_ok     = 1'b0;
    case (item.action)
      ACT_MOVE: begin
        job_ok   = 1'b1;
        job.cmd  = CMD_MOVE;
        job.nprm = 3'd4;
        job.prm  = {t_cl[15:8], t_cl[7:0], a_cl[15:8], a_cl[7:0]};
      end
      ACT_STOP: begin
        job_ok  = 1'b1;
        job.cmd = CMD_STOP;
      end
      ACT_SET_ID: begin
        job_ok     = (item.new_id <= ID_MAX);
        job.cmd    = CMD_ID;
        job.nprm   = 3'd1;
        job.prm[0] = item.new_id;
      end
      ACT_LIMIT: begin
        job_ok   = (item.angle < item.second_angle) && (item.second_angle <= ANGLE_MAX);
        job.cmd  = CMD_LIMIT;
        job.nprm = 3'd4;
        job.prm  = {item.second_angle[15:8], item.second_angle[7:0],
                    item.angle[15:8], item.angle[7:0]};
      end
      ACT_LOAD, ACT_UNLOAD: begin
        job_ok     = 1'b1;
        job.cmd    = CMD_LOAD;
        job.nprm   = 3'd1;
        job.prm[0] = {7'd0, (item.action == ACT_LOAD)};
      end
      ACT_READ: begin
        job_ok  = 1'b1;
        job.cmd = CMD_POS;
      end
      ACT_RX: begin
        // The eighth reply byte is the checksum: judge the stored reply now.
        job_ok      = awaiting && (reply_count == REPLY_STORED);
        job.is_read = 1'b1;
        if (reply_bytes[0] != HDR || reply_bytes[1] != HDR) begin
          job.status = ST_HEADER;
        end else if (reply_bytes[2] != current_id || reply_bytes[4] != CMD_POS) begin
          job.status = ST_MISMATCH;
        end else if (item.rx_byte != ~reply_sum) begin
          job.status = ST_CHECKSUM;
        end else begin
          job.status = ST_OK;
          job.angle  = {reply_bytes[6], reply_bytes[5]};
        end
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase

    len       = job.nprm + 3'd3;
    frame_sum = job.id + {5'd0, len} + job.cmd + job.prm[0] + job.prm[1]
              + job.prm[2] + job.prm[3];
    job.chk   = ~frame_sum;
  end

  assign job_push = accept && job_ok;

  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_RX && awaiting && reply_count != REPLY_STORED) begin
      reply_bytes[reply_count] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_id  <= ID_RESET;
      awaiting    <= 1'b0;
      reply_count <= 3'd0;
    end else if (cfg_write) begin
      current_id <= cfg_id;
    end else if (accept) begin
      case (item.action)
        ACT_SET_ID: begin
          awaiting <= 1'b0;
          if (job_ok) begin
            current_id <= item.new_id;
          end
        end
        ACT_READ: begin
          awaiting    <= 1'b1;
          reply_count <= 3'd0;
        end
        ACT_RX: begin
          if (awaiting) begin
            if (reply_count == REPLY_STORED) begin
              awaiting    <= 1'b0;
              reply_count <= 3'd0;
            end else begin
              reply_count <= reply_count + 3'd1;
            end
          end
        end
        default: begin
          awaiting <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sbpe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sbpe_back import sbpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_empty,
  output logic      job_pop,
  output res_t      result,
  output logic      empty,
  input  wire logic pop
);

  logic [3:0] idx;
  logic       out_valid;
  logic       advance;
  logic       last;
  logic [3:0] total;
  logic [3:0] chk_idx;
  logic [1:0] prm_idx;
  res_t       res_next;

  assign empty   = !out_valid;
  assign advance = !job_empty && (!out_valid || pop);
  assign job_pop = advance && last;

  always_comb begin
    total   = {1'b0, job.nprm} + 4'd6;
    chk_idx = {1'b0, job.nprm} + 4'd5;
    prm_idx = 2'(idx - 4'd5);
    last    = job.is_read || (idx == total - 4'd1);

    res_next            = '0;
    res_next.kind       = job.is_read;
    res_next.frame_last = last;
    if (job.is_read) begin
      res_next.read_status = job.status;
      res_next.read_angle  = job.angle;
    end else if (idx < 4'd2) begin
      res_next.tx_byte = HDR;
    end else if (idx == 4'd2) begin
      res_next.tx_byte = job.id;
    end else if (idx == 4'd3) begin
      res_next.tx_byte = {5'd0, job.nprm + 3'd3};
    end else if (idx == 4'd4) begin
      res_next.tx_byte = job.cmd;
    end else if (idx == chk_idx) begin
      res_next.tx_byte = job.chk;
    end else begin
      res_next.tx_byte = job.prm[prm_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= last ? 4'd0 : idx + 4'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/servo_bus_packet_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake          Payload
// command   push / full        cmd_t   (action, angles, time, new id, rx byte)
// result    pop / empty        res_t   (kind, tx byte, last flag, status, angle)
// config    cfg_valid/ready    cfg_data (start id, loaded into current id)
//
// A frame leaves one byte per cycle unless results stall, 6 to 10 bytes per
// command; a read result is one item. The byte serializer sets this rate.
// The front classifies and updates the id and reply state as soon as an item
// is taken; a two-entry job queue lets it run ahead while the result side
// stalls. Reset is synchronous; current id returns to 1 and no reply is armed.
module servo_bus_packet_engine import sbpe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire cmd_t       command,
  output logic            empty,
  input  wire logic       pop,
  output res_t            result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic job_push;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_head;

  assign cfg_ready = 1'b1;

  sbpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !full),
    .item      (command),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_id    (cfg_data),
    .job_push  (job_push),
    .job       (job_in)
  );

  sbpe_job_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  sbpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
